@@ rtl/core/pcmt_pkg.sv @@
// Package for the per-client message counter table.
// Holds field widths, command, status and query-select codes and the default table depth.
// No dependencies.
package pcmt_pkg;

  localparam int MAX_CONTEXTS_DEF = 64;

  localparam int CMD_W   = 3;
  localparam int CTX_W   = 6;
  localparam int SEL_W   = 3;
  localparam int STAT_W  = 2;
  localparam int CNT_W   = 32;

  localparam int IN_DATA_W  = 16;   // context_req, all_contexts, query_select, zero fill
  localparam int OUT_DATA_W = 160;  // five 32-bit counters

  // commands
  localparam logic [CMD_W-1:0] CMD_RECV   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_XMIT   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_END    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLR_RX = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLR_TX = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_CTX  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_BAD_SEL = 2'd3;

  // query selects
  localparam logic [SEL_W-1:0] SEL_SUM     = 3'd0;
  localparam logic [SEL_W-1:0] SEL_RECV    = 3'd1;
  localparam logic [SEL_W-1:0] SEL_XMIT    = 3'd2;
  localparam logic [SEL_W-1:0] SEL_HWATER  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_ACTIVE  = 3'd4;
  localparam logic [SEL_W-1:0] SEL_STARTED = 3'd5;
  localparam logic [SEL_W-1:0] SEL_ENDED   = 3'd6;

endpackage

@@ rtl/core/per_client_message_counter_table.sv @@
// Per-client message counter table: top level with sequencer, shared 32-bit adder and counter RAMs.
// Depends on pcmt_pkg and pcmt_ram.
// Sequence: RAM read, load, up to three adder steps, then the output load; clear-all
//   instead walks the table, one table entry per cycle, before the output load.
// Requests are taken one at a time, only in idle; a stalled result holds the block in its done state.
// Reset: synchronous active-low; clears control, active flags and totals, not the counter RAMs.
module per_client_message_counter_table #(
  parameter int MAX_CONTEXTS = pcmt_pkg::MAX_CONTEXTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // request channel
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pcmt_pkg::IN_DATA_W-1:0]   in_tdata,  // context_req[5:0], all_contexts[6],
                                                      // query_select[9:7], zero [15:10]
  input  logic [pcmt_pkg::CMD_W-1:0]       in_tuser,  // command[2:0]
  // result channel
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [pcmt_pkg::OUT_DATA_W-1:0]  out_tdata, // recv_count[31:0], xmit_count[63:32],
                                                      // all_recv[95:64], all_xmit[127:96],
                                                      // query_value[159:128]
  output logic [pcmt_pkg::STAT_W-1:0]      out_tuser  // status[1:0]
);

  localparam int IDX_W = (MAX_CONTEXTS > 1) ? $clog2(MAX_CONTEXTS) : 1;
  localparam int HW_W  = $clog2(MAX_CONTEXTS + 1);
  localparam int CW    = pcmt_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_LOAD, S_OP, S_SWEEP, S_DONE
  } state_t;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t                      state_r,     state_nxt;
  logic [1:0]                  step_r,      step_nxt;
  logic [pcmt_pkg::CMD_W-1:0]  cmd_r,       cmd_nxt;
  logic [pcmt_pkg::CTX_W-1:0]  ctx_r,       ctx_nxt;
  logic                        all_r,       all_nxt;
  logic [pcmt_pkg::SEL_W-1:0]  sel_r,       sel_nxt;
  logic                        live_r,      live_nxt;
  logic [CW-1:0]               rc_r,        rc_nxt;
  logic [CW-1:0]               xc_r,        xc_nxt;
  logic [CW-1:0]               qv_r,        qv_nxt;
  logic [pcmt_pkg::STAT_W-1:0] status_r,    status_nxt;
  logic [IDX_W-1:0]            sweep_r,     sweep_nxt;
  logic [MAX_CONTEXTS-1:0]     active_r,    active_nxt;
  logic [HW_W-1:0]             hw_r,        hw_nxt;
  logic [HW_W-1:0]             act_cnt_r,   act_cnt_nxt;
  logic [CW-1:0]               started_r,   started_nxt;
  logic [CW-1:0]               ended_r,     ended_nxt;
  logic [CW-1:0]               closed_rx_r, closed_rx_nxt;
  logic [CW-1:0]               closed_tx_r, closed_tx_nxt;
  logic [CW-1:0]               all_rx_r,    all_rx_nxt;
  logic [CW-1:0]               all_tx_r,    all_tx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [pcmt_pkg::STAT_W-1:0] out_user_r,  out_user_nxt;
  logic [pcmt_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------------
  // Shared adder: a + b, or a - b when sub is set
  // ---------------------------------------------------------------------------
  logic [CW-1:0] add_a, add_b, add_sum;
  logic          add_sub;

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + CW'(add_sub);

  // ---------------------------------------------------------------------------
  // Counter RAMs, one per direction
  // ---------------------------------------------------------------------------
  logic             rx_we, tx_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [CW-1:0]    rx_wdata, tx_wdata, rx_rdata, tx_rdata;
  logic [IDX_W-1:0] ctx_idx;
  logic             in_range;
  logic             last_step;

  assign ctx_idx  = IDX_W'(ctx_r);
  assign in_range = 32'(ctx_r) < 32'(MAX_CONTEXTS);

  pcmt_ram #(.WIDTH(CW), .DEPTH(MAX_CONTEXTS)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (ram_waddr),
    .wdata (rx_wdata),
    .raddr (ctx_idx),
    .rdata (rx_rdata)
  );

  pcmt_ram #(.WIDTH(CW), .DEPTH(MAX_CONTEXTS)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (ram_waddr),
    .wdata (tx_wdata),
    .raddr (ctx_idx),
    .rdata (tx_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Last adder step of each command sequence.
  always_comb begin
    case (cmd_r)
      pcmt_pkg::CMD_RECV: last_step = (step_r == 2'd2);
      pcmt_pkg::CMD_END:  last_step = (step_r == 2'd2);
      pcmt_pkg::CMD_XMIT: last_step = (step_r == 2'd1);
      default:            last_step = 1'b1;
    endcase
  end

  // Adder operand select per command and step.
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (cmd_r)
      pcmt_pkg::CMD_RECV: begin
        case (step_r)
          2'd0: begin
            add_a = live_r ? rc_r : '0;
            add_b = CW'(1);
          end
          2'd1: begin
            add_a = all_rx_r;
            add_b = CW'(1);
          end
          default: begin
            add_a = started_r;
            add_b = CW'(!live_r);
          end
        endcase
      end
      pcmt_pkg::CMD_XMIT: begin
        add_a = (step_r == 2'd0) ? xc_r : all_tx_r;
        add_b = CW'(1);
      end
      pcmt_pkg::CMD_END: begin
        case (step_r)
          2'd0: begin
            add_a = closed_rx_r;
            add_b = rc_r;
          end
          2'd1: begin
            add_a = closed_tx_r;
            add_b = xc_r;
          end
          default: begin
            add_a = ended_r;
            add_b = CW'(1);
          end
        endcase
      end
      pcmt_pkg::CMD_CLR_RX: begin
        add_a   = all_rx_r;
        add_b   = rc_r;
        add_sub = 1'b1;
      end
      pcmt_pkg::CMD_CLR_TX: begin
        add_a   = all_tx_r;
        add_b   = xc_r;
        add_sub = 1'b1;
      end
      pcmt_pkg::CMD_QUERY: begin
        add_a = rc_r;
        add_b = xc_r;
      end
      default: begin
        add_a = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next-state and register updates
  // ---------------------------------------------------------------------------
  always_comb begin
    logic live_now;

    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd_nxt       = cmd_r;
    ctx_nxt       = ctx_r;
    all_nxt       = all_r;
    sel_nxt       = sel_r;
    live_nxt      = live_r;
    rc_nxt        = rc_r;
    xc_nxt        = xc_r;
    qv_nxt        = qv_r;
    status_nxt    = status_r;
    sweep_nxt     = sweep_r;
    active_nxt    = active_r;
    hw_nxt        = hw_r;
    act_cnt_nxt   = act_cnt_r;
    started_nxt   = started_r;
    ended_nxt     = ended_r;
    closed_rx_nxt = closed_rx_r;
    closed_tx_nxt = closed_tx_r;
    all_rx_nxt    = all_rx_r;
    all_tx_nxt    = all_tx_r;
    out_valid_nxt = out_valid_r;
    out_user_nxt  = out_user_r;
    out_data_nxt  = out_data_r;

    rx_we     = 1'b0;
    tx_we     = 1'b0;
    ram_waddr = ctx_idx;
    rx_wdata  = add_sum;
    tx_wdata  = add_sum;

    live_now = in_range && active_r[ctx_idx];

    // drop the result once it is taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          ctx_nxt   = in_tdata[5:0];
          all_nxt   = in_tdata[6];
          sel_nxt   = in_tdata[9:7];
          state_nxt = S_READ;
        end
      end

      // RAM read of the addressed context is in flight
      S_READ: begin
        state_nxt = S_LOAD;
      end

      S_LOAD: begin
        rc_nxt     = rx_rdata;
        xc_nxt     = tx_rdata;
        live_nxt   = live_now;
        qv_nxt     = '0;
        status_nxt = pcmt_pkg::STAT_OK;
        step_nxt   = 2'd0;
        sweep_nxt  = '0;
        state_nxt  = S_DONE;
        case (cmd_r)
          pcmt_pkg::CMD_RECV: begin
            if (!in_range) begin
              status_nxt = pcmt_pkg::STAT_FULL;
            end else begin
              state_nxt = S_OP;
            end
          end
          pcmt_pkg::CMD_XMIT,
          pcmt_pkg::CMD_END: begin
            if (!live_now) begin
              status_nxt = pcmt_pkg::STAT_NO_CTX;
            end else begin
              state_nxt = S_OP;
            end
          end
          pcmt_pkg::CMD_CLR_RX,
          pcmt_pkg::CMD_CLR_TX: begin
            if (all_r) begin
              // every active counter of this direction becomes zero
              if (cmd_r == pcmt_pkg::CMD_CLR_RX) begin
                rc_nxt = '0;
              end else begin
                xc_nxt = '0;
              end
              state_nxt = S_SWEEP;
            end else if (!live_now) begin
              status_nxt = pcmt_pkg::STAT_NO_CTX;
            end else begin
              state_nxt = S_OP;
            end
          end
          pcmt_pkg::CMD_QUERY: begin
            if (!live_now) begin
              status_nxt = pcmt_pkg::STAT_NO_CTX;
            end else begin
              case (sel_r)
                pcmt_pkg::SEL_SUM:     state_nxt = S_OP;
                pcmt_pkg::SEL_RECV:    qv_nxt = rx_rdata;
                pcmt_pkg::SEL_XMIT:    qv_nxt = tx_rdata;
                pcmt_pkg::SEL_HWATER:  qv_nxt = CW'(hw_r);
                pcmt_pkg::SEL_ACTIVE:  qv_nxt = CW'(act_cnt_r);
                pcmt_pkg::SEL_STARTED: qv_nxt = started_r;
                pcmt_pkg::SEL_ENDED:   qv_nxt = ended_r;
                default:               status_nxt = pcmt_pkg::STAT_BAD_SEL;
              endcase
            end
          end
          default: begin
            // unused commands: no change
            status_nxt = pcmt_pkg::STAT_OK;
          end
        endcase
      end

      S_OP: begin
        step_nxt = step_r + 2'd1;
        if (last_step) begin
          state_nxt = S_DONE;
        end
        case (cmd_r)
          pcmt_pkg::CMD_RECV: begin
            case (step_r)
              2'd0: begin
                // activate on first receive, then count
                rc_nxt = add_sum;
                rx_we  = 1'b1;
                if (!live_r) begin
                  xc_nxt               = '0;
                  tx_we                = 1'b1;
                  tx_wdata             = '0;
                  active_nxt[ctx_idx]  = 1'b1;
                  act_cnt_nxt          = act_cnt_r + HW_W'(1);
                end
                if (HW_W'(ctx_idx) >= hw_r) begin
                  hw_nxt = HW_W'(ctx_idx) + HW_W'(1);
                end
              end
              2'd1:    all_rx_nxt  = add_sum;
              default: started_nxt = add_sum;
            endcase
          end
          pcmt_pkg::CMD_XMIT: begin
            if (step_r == 2'd0) begin
              xc_nxt = add_sum;
              tx_we  = 1'b1;
            end else begin
              all_tx_nxt = add_sum;
            end
          end
          pcmt_pkg::CMD_END: begin
            // fold into closed totals; running sums are unchanged
            case (step_r)
              2'd0: closed_rx_nxt = add_sum;
              2'd1: closed_tx_nxt = add_sum;
              default: begin
                ended_nxt           = add_sum;
                active_nxt[ctx_idx] = 1'b0;
                act_cnt_nxt         = act_cnt_r - HW_W'(1);
              end
            endcase
          end
          pcmt_pkg::CMD_CLR_RX: begin
            all_rx_nxt = add_sum;
            rc_nxt     = '0;
            rx_we      = 1'b1;
            rx_wdata   = '0;
          end
          pcmt_pkg::CMD_CLR_TX: begin
            all_tx_nxt = add_sum;
            xc_nxt     = '0;
            tx_we      = 1'b1;
            tx_wdata   = '0;
          end
          pcmt_pkg::CMD_QUERY: begin
            qv_nxt = add_sum;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // walk the table one entry per cycle, zeroing the active entries
      S_SWEEP: begin
        ram_waddr = sweep_r;
        rx_wdata  = '0;
        tx_wdata  = '0;
        if (cmd_r == pcmt_pkg::CMD_CLR_RX) begin
          rx_we = active_r[sweep_r];
        end else begin
          tx_we = active_r[sweep_r];
        end
        sweep_nxt = sweep_r + IDX_W'(1);
        if (sweep_r == IDX_W'(MAX_CONTEXTS - 1)) begin
          if (cmd_r == pcmt_pkg::CMD_CLR_RX) begin
            closed_rx_nxt = '0;
            all_rx_nxt    = '0;
          end else begin
            closed_tx_nxt = '0;
            all_tx_nxt    = '0;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = {(status_r == pcmt_pkg::STAT_OK) ? qv_r : CW'(0),
                           all_tx_r,
                           all_rx_r,
                           live_now ? xc_r : CW'(0),
                           live_now ? rc_r : CW'(0)};
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      active_r    <= '0;
      hw_r        <= '0;
      act_cnt_r   <= '0;
      started_r   <= '0;
      ended_r     <= '0;
      closed_rx_r <= '0;
      closed_tx_r <= '0;
      all_rx_r    <= '0;
      all_tx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      active_r    <= active_nxt;
      hw_r        <= hw_nxt;
      act_cnt_r   <= act_cnt_nxt;
      started_r   <= started_nxt;
      ended_r     <= ended_nxt;
      closed_rx_r <= closed_rx_nxt;
      closed_tx_r <= closed_tx_nxt;
      all_rx_r    <= all_rx_nxt;
      all_tx_r    <= all_tx_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    ctx_r      <= ctx_nxt;
    all_r      <= all_nxt;
    sel_r      <= sel_nxt;
    live_r     <= live_nxt;
    rc_r       <= rc_nxt;
    xc_r       <= xc_nxt;
    qv_r       <= qv_nxt;
    status_r   <= status_nxt;
    sweep_r    <= sweep_nxt;
    out_user_r <= out_user_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

@@ rtl/core/pcmt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/pcmt_checker.sv @@
// Port-level checker for the per-client message counter table, with its bind.
// Depends on pcmt_pkg and the top-level port list.
module pcmt_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pcmt_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [pcmt_pkg::STAT_W-1:0]      out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // any error status carries a zero statistic
  a_err_qv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != pcmt_pkg::STAT_OK) |-> out_tdata[159:128] == '0)
    else $error("nonzero statistic with error status");

  // a missing or out-of-range context reports zero counts
  a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == pcmt_pkg::STAT_NO_CTX || out_tuser == pcmt_pkg::STAT_FULL)
    |-> out_tdata[63:0] == '0)
    else $error("nonzero counts for inactive context");

endmodule

bind per_client_message_counter_table pcmt_checker u_pcmt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ tb/per_client_message_counter_table_tb.sv @@
// Self-checking testbench for per_client_message_counter_table: directed and random requests.
// A scoreboard class tracks the context table and checks every result in order.
// Depends on pcmt_pkg and the per_client_message_counter_table RTL.
module per_client_message_counter_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pcmt_pkg::*;

  localparam int TABLE_DEPTH   = MAX_CONTEXTS_DEF;
  localparam int RANDOM_ITEMS  = 1800;
  localparam int LIMIT_CYCLES  = 1000000;
  // Clear-all walks the whole table, so let that much settle after the last result.
  localparam int DRAIN_CYCLES  = TABLE_DEPTH + 16;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_AFTER    = 300;

  // Command and select codes the package leaves unnamed.
  localparam logic [CMD_W-1:0] CMD_NOP_LO  = 3'd6;
  localparam logic [CMD_W-1:0] CMD_NOP_HI  = 3'd7;
  localparam logic [SEL_W-1:0] SEL_INVALID = 3'd7;

  // Result sink behavior within one segment.
  localparam int SINK_OPEN   = 0;
  localparam int SINK_RANDOM = 1;
  localparam int SINK_CHOKED = 2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [CTX_W-1:0] ctx;
    logic             all_ctx;
    logic [SEL_W-1:0] sel;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  recv_count;
    logic [CNT_W-1:0]  xmit_count;
    logic [CNT_W-1:0]  all_recv;
    logic [CNT_W-1:0]  all_xmit;
    logic [CNT_W-1:0]  query_value;
  } res_t;

  // Tracks the context table and keeps the results still owed by the block.
  class counter_table_tracker;
    bit             live[TABLE_DEPTH];
    bit [CNT_W-1:0] rx_cnt[TABLE_DEPTH];
    bit [CNT_W-1:0] tx_cnt[TABLE_DEPTH];
    bit [6:0]       hwm;
    bit [CNT_W-1:0] started;
    bit [CNT_W-1:0] ended;
    bit [CNT_W-1:0] closed_rx;
    bit [CNT_W-1:0] closed_tx;
    res_t           pending_results[$];
    int             fail_count;

    function new();
      foreach (live[i]) begin
        live[i] = 1'b0;
        rx_cnt[i] = '0;
        tx_cnt[i] = '0;
      end
      hwm = '0;
      started = '0;
      ended = '0;
      closed_rx = '0;
      closed_tx = '0;
      fail_count = 0;
    endfunction

    // Advance the table by one request and return the result it must produce.
    function res_t apply_request(req_t r);
      res_t           e;
      bit [CNT_W-1:0] qv;
      bit [CNT_W-1:0] sum_rx;
      bit [CNT_W-1:0] sum_tx;
      logic [STAT_W-1:0] st;
      st = STAT_OK;
      qv = '0;
      case (r.cmd)
        CMD_RECV: begin
          if (r.ctx >= TABLE_DEPTH) begin
            st = STAT_FULL;
          end else begin
            if ({1'b0, r.ctx} >= hwm) hwm = {1'b0, r.ctx} + 7'd1;
            if (!live[r.ctx]) begin
              started++;
              live[r.ctx] = 1'b1;
              rx_cnt[r.ctx] = '0;
              tx_cnt[r.ctx] = '0;
            end
            rx_cnt[r.ctx]++;
          end
        end
        CMD_XMIT: begin
          if (!live[r.ctx]) st = STAT_NO_CTX;
          else tx_cnt[r.ctx]++;
        end
        CMD_END: begin
          if (!live[r.ctx]) begin
            st = STAT_NO_CTX;
          end else begin
            ended++;
            closed_rx += rx_cnt[r.ctx];
            closed_tx += tx_cnt[r.ctx];
            live[r.ctx] = 1'b0;
          end
        end
        CMD_CLR_RX, CMD_CLR_TX: begin
          if (r.all_ctx) begin
            // Clear-all never fails, and also drops the closed total.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
              if (live[i]) begin
                if (r.cmd == CMD_CLR_RX) rx_cnt[i] = '0;
                else tx_cnt[i] = '0;
              end
            end
            if (r.cmd == CMD_CLR_RX) closed_rx = '0;
            else closed_tx = '0;
          end else if (!live[r.ctx]) begin
            st = STAT_NO_CTX;
          end else if (r.cmd == CMD_CLR_RX) begin
            rx_cnt[r.ctx] = '0;
          end else begin
            tx_cnt[r.ctx] = '0;
          end
        end
        CMD_QUERY: begin
          // The context check wins over a bad select.
          if (!live[r.ctx]) begin
            st = STAT_NO_CTX;
          end else begin
            case (r.sel)
              SEL_SUM:     qv = rx_cnt[r.ctx] + tx_cnt[r.ctx];
              SEL_RECV:    qv = rx_cnt[r.ctx];
              SEL_XMIT:    qv = tx_cnt[r.ctx];
              SEL_HWATER:  qv = CNT_W'(hwm);
              SEL_ACTIVE: begin
                for (int i = 0; i < TABLE_DEPTH; i++) qv += CNT_W'(live[i]);
              end
              SEL_STARTED: qv = started;
              SEL_ENDED:   qv = ended;
              default:     st = STAT_BAD_SEL;
            endcase
          end
        end
        default: ;  // unused commands change nothing
      endcase

      sum_rx = closed_rx;
      sum_tx = closed_tx;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (live[i]) begin
          sum_rx += rx_cnt[i];
          sum_tx += tx_cnt[i];
        end
      end

      e.status      = st;
      e.recv_count  = live[r.ctx] ? rx_cnt[r.ctx] : '0;
      e.xmit_count  = live[r.ctx] ? tx_cnt[r.ctx] : '0;
      e.all_recv    = sum_rx;
      e.all_xmit    = sum_tx;
      e.query_value = (st == STAT_OK) ? qv : '0;
      return e;
    endfunction

    function void note_request(req_t r);
      pending_results.push_back(apply_request(r));
    endfunction

    function void compare_field(string name, bit [CNT_W-1:0] want, bit [CNT_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        fail_count++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual status %0d recv %0d xmit %0d",
                 $time, got.status, got.recv_count, got.xmit_count);
        fail_count++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("status", CNT_W'(want.status), CNT_W'(got.status));
      compare_field("recv_count", want.recv_count, got.recv_count);
      compare_field("xmit_count", want.xmit_count, got.xmit_count);
      compare_field("all_recv", want.all_recv, got.all_recv);
      compare_field("all_xmit", want.all_xmit, got.all_xmit);
      compare_field("query_value", want.query_value, got.query_value);
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_DATA_W-1:0]    in_tdata;   // context_req[5:0], all_contexts[6], query_select[9:7]
  logic [CMD_W-1:0]        in_tuser;   // command[2:0]
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_DATA_W-1:0]   out_tdata;  // recv, xmit, all_recv, all_xmit, query_value
  logic [STAT_W-1:0]       out_tuser;  // status[1:0]

  counter_table_tracker tracker = new();
  int results_seen = 0;
  int cycle_count = 0;

  per_client_message_counter_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Give up on a hung block well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("per_client_message_counter_table_tb failed");
      $finish;
    end
  end

  // Sample both handshakes at the rising edge; inputs and ready only move at the falling edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        tracker.note_request('{cmd: in_tuser, ctx: in_tdata[5:0], all_ctx: in_tdata[6],
                               sel: in_tdata[9:7]});
      end
      if (out_tvalid && out_tready) begin
        tracker.check_result('{status: out_tuser, recv_count: out_tdata[31:0],
                               xmit_count: out_tdata[63:32], all_recv: out_tdata[95:64],
                               all_xmit: out_tdata[127:96], query_value: out_tdata[159:128]});
        results_seen++;
      end
    end
  end

  // Hold one request on the bus until the block takes it.
  task automatic push_request(input req_t r);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {{(IN_DATA_W - CTX_W - 1 - SEL_W){1'b0}}, r.sel, r.all_ctx, r.ctx};
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid for a number of cycles.
  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  function automatic req_t mk_req(logic [CMD_W-1:0] cmd, int ctx, bit all_ctx,
                                  logic [SEL_W-1:0] sel);
    req_t r;
    r.cmd = cmd;
    r.ctx = ctx[CTX_W-1:0];
    r.all_ctx = all_ctx;
    r.sel = sel;
    return r;
  endfunction

  // Random request: mostly traffic on a small pool of contexts so that sessions live long
  // enough to be counted, transmitted on, queried and ended; the rest hits anywhere.
  function automatic req_t rand_request(ref bit [CTX_W-1:0] pool[8]);
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      r.cmd = CMD_RECV;
    else if (pick < 55) r.cmd = CMD_XMIT;
    else if (pick < 63) r.cmd = CMD_END;
    else if (pick < 70) r.cmd = CMD_CLR_RX;
    else if (pick < 77) r.cmd = CMD_CLR_TX;
    else if (pick < 96) r.cmd = CMD_QUERY;
    else if (pick < 98) r.cmd = CMD_NOP_LO;
    else                r.cmd = CMD_NOP_HI;
    if ($urandom_range(0, 3) != 0) r.ctx = pool[$urandom_range(0, 7)];
    else r.ctx = CTX_W'($urandom_range(0, TABLE_DEPTH - 1));
    // Clear-all walks the whole table; keep it to a fraction of the clears.
    if (r.cmd == CMD_CLR_RX || r.cmd == CMD_CLR_TX) r.all_ctx = ($urandom_range(0, 4) == 0);
    else r.all_ctx = 1'($urandom_range(0, 1));
    if (r.cmd == CMD_QUERY && $urandom_range(0, 15) != 0) r.sel = SEL_W'($urandom_range(0, 6));
    else if (r.cmd == CMD_QUERY) r.sel = SEL_INVALID;
    else r.sel = SEL_W'($urandom_range(0, 7));
    return r;
  endfunction

  // Result sink: segments of random length, each open, random or mostly stalled, plus one
  // long hold-off so the block backs up and stalls its request side.
  initial begin : result_sink
    int seg_left;
    int mode;
    int hold_left;
    bit hold_done;
    out_tready = 1'b0;
    seg_left = 0;
    mode = SINK_OPEN;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(1, 40);
          mode = $urandom_range(SINK_OPEN, SINK_CHOKED);
        end
        seg_left--;
        case (mode)
          SINK_OPEN:   out_tready <= 1'b1;
          SINK_RANDOM: out_tready <= 1'($urandom_range(0, 1));
          default:     out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    req_t            r;
    bit [CTX_W-1:0]  pool[8];
    int              burst;
    int              real_items;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_RECV;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: misses on an empty table, both table edges, every select, unused commands.
    push_request(mk_req(CMD_QUERY, 0, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_XMIT, TABLE_DEPTH - 1, 1'b1, SEL_INVALID));
    push_request(mk_req(CMD_END, 5, 1'b0, SEL_RECV));
    push_request(mk_req(CMD_CLR_RX, 9, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_CLR_RX, 0, 1'b1, SEL_SUM));
    push_request(mk_req(CMD_RECV, 0, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_RECV, TABLE_DEPTH - 1, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_RECV, TABLE_DEPTH - 1, 1'b1, SEL_INVALID));
    push_request(mk_req(CMD_XMIT, TABLE_DEPTH - 1, 1'b0, SEL_SUM));
    for (int s = 0; s < 8; s++) begin
      push_request(mk_req(CMD_QUERY, TABLE_DEPTH - 1, s[0], s[SEL_W-1:0]));
    end
    push_request(mk_req(CMD_CLR_TX, TABLE_DEPTH - 1, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_CLR_RX, 7, 1'b1, SEL_SUM));
    push_request(mk_req(CMD_NOP_LO, 0, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_NOP_HI, TABLE_DEPTH - 1, 1'b1, SEL_INVALID));
    push_request(mk_req(CMD_END, TABLE_DEPTH - 1, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_QUERY, TABLE_DEPTH - 1, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_RECV, TABLE_DEPTH - 1, 1'b0, SEL_SUM));
    push_request(mk_req(CMD_CLR_TX, 3, 1'b1, SEL_SUM));

    // Random: bursts with gaps; refresh the context pool now and then.
    foreach (pool[i]) pool[i] = CTX_W'($urandom_range(0, TABLE_DEPTH - 1));
    real_items = 0;
    while (real_items < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        r = rand_request(pool);
        push_request(r);
        if (r.cmd != CMD_NOP_LO && r.cmd != CMD_NOP_HI) real_items++;
      end
      if ($urandom_range(0, 3) == 0) begin
        pool[$urandom_range(0, 7)] = CTX_W'($urandom_range(0, TABLE_DEPTH - 1));
      end
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 12));
    end
    idle_sender(1);

    // Drain every outstanding result, then watch for strays.
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.fail_count == 0) begin
      $display("per_client_message_counter_table_tb passed");
    end else begin
      $display("per_client_message_counter_table_tb failed");
    end
    $finish;
  end

endmodule
